[design/ppe_pkg.sv]
package ppe_pkg;

   localparam int PoolSize = 256;
   localparam int SlotBits = $clog2(PoolSize);
   localparam int CntBits  = SlotBits + 1;

   typedef enum logic [1:0] {
      MODE_SPAWN = 2'd0,
      MODE_TICK  = 2'd1,
      MODE_READ  = 2'd2,
      MODE_NOP   = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SPAWN_WR,
      ST_TICK_RD,
      ST_TICK_LIFE,
      ST_TICK_VY,
      ST_TICK_AX,
      ST_TICK_WR,
      ST_READ_RD,
      ST_READ_DIV,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MUL_GRAV = 2'd0,
      MUL_VEL  = 2'd1
   } mul_sel_type;

   function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
      if (v > 19'sd32767) begin
         sat16 = 16'sh7fff;
      end else if (v < -19'sd32768) begin
         sat16 = 16'sh8000;
      end else begin
         sat16 = v[15:0];
      end
   endfunction

endpackage

[design/particle_pool_engine.sv]
// Particle pool of 256 slots, one word in and one word out per operation.
// Spawn scans the live marks one slot a cycle for the lowest free slot,
// then writes it, falling back to the ring head when all are live. Tick
// walks every slot. A live slot goes through memory read, life update,
// gravity, three position axes through one shared multiply/saturate unit,
// and write back. A slot whose life runs out is freed after the life
// update, and a free slot is only stepped past. Read takes a memory read
// plus four colour divisions on one shared restoring divider, none when
// the maximum life is zero. The block accepts no word while an
// operation is in progress, nor while a finished result waits under
// rsp_stall; the result sits in an output register and holds while rsp_stall
// is high. Slot storage is not cleared by reset; only live marks and the
// ring head are.
module particle_pool_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_slot_index,
   input  logic [47:0] req_position,
   input  logic [47:0] req_velocity,
   input  logic [15:0] req_particle_size,
   input  logic [15:0] req_lifetime,
   input  logic signed [15:0] req_gravity_accel,
   input  logic [63:0] req_colours,
   input  logic        req_additive_blend,
   input  logic [15:0] req_time_step,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_taken_slot,
   output logic        rsp_overwrote,
   output logic        rsp_is_active,
   output logic        rsp_is_additive,
   output logic [47:0] rsp_cur_position,
   output logic [15:0] rsp_cur_size,
   output logic [31:0] rsp_cur_colour
);
   localparam int SB = ppe_pkg::SlotBits;
   localparam int CB = ppe_pkg::CntBits;

   ppe_pkg::state_type state_ff, state_in;

   // slot storage (single write port, registered read)
   logic [47:0] mem_pos   [ppe_pkg::PoolSize];
   logic [47:0] mem_vel   [ppe_pkg::PoolSize];
   logic [15:0] mem_life  [ppe_pkg::PoolSize];
   logic [15:0] mem_maxl  [ppe_pkg::PoolSize];
   logic [96:0] mem_misc  [ppe_pkg::PoolSize];  // additive, gravity, colours, size
   logic [ppe_pkg::PoolSize-1:0] live_ff, live_in;
   logic [SB-1:0] head_ff, head_in;

   // captured request
   logic [7:0]  idx_ff, idx_in;
   logic [47:0] pos_q_ff, pos_q_in;
   logic [47:0] vel_q_ff, vel_q_in;
   logic [15:0] size_q_ff, size_q_in, life_q_ff, life_q_in, grav_q_ff, grav_q_in;
   logic [63:0] col_q_ff, col_q_in;
   logic        add_q_ff, add_q_in;
   logic [15:0] dt_ff, dt_in;

   logic [CB-1:0] cnt_ff, cnt_in;
   logic [1:0]    ax_ff, ax_in;     // axis or colour channel counter

   // working copy of one slot
   logic [47:0] w_pos_ff, w_pos_in, w_vel_ff, w_vel_in;
   logic [15:0] w_life_ff, w_life_in, w_maxl_ff, w_maxl_in;
   logic [96:0] w_misc_ff, w_misc_in;
   logic [47:0] rd_pos, rd_vel;
   logic [15:0] rd_life, rd_maxl;
   logic [96:0] rd_misc;

   logic [31:0] colour_ff, colour_in;

   // result register
   logic        ovalid_ff, ovalid_in;
   logic [7:0]  o_slot_ff, o_slot_in;
   logic        o_ovw_ff, o_ovw_in, o_act_ff, o_act_in, o_add_ff, o_add_in;
   logic [47:0] o_pos_ff, o_pos_in;
   logic [15:0] o_size_ff, o_size_in;
   logic [31:0] o_col_ff, o_col_in;

   // memory control
   logic          mem_we;
   logic [SB-1:0] mem_waddr, mem_raddr;
   logic [47:0]   wd_pos, wd_vel;
   logic [15:0]   wd_life, wd_maxl;
   logic [96:0]   wd_misc;

   // shared scale unit
   logic signed [15:0] sc_a, sc_base, sc_res;
   logic               sc_sub;

   // shared divider
   logic        dv_start, dv_done;
   logic [23:0] dv_num;
   logic [7:0]  dv_q;

   logic [SB-1:0] cur_slot;
   logic [19:0]   l16;
   logic [7:0]    ch_a, ch_b;
   logic [15:0]   life_c, elapsed;

   assign cur_slot = cnt_ff[SB-1:0];
   assign l16      = {rd_life, 4'd0};

   ppe_scale u_scale (
      .a      (sc_a),
      .dt     (dt_ff),
      .base   (sc_base),
      .sub    (sc_sub),
      .result (sc_res)
   );

   ppe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dv_start),
      .dividend (dv_num),
      .divisor  (w_maxl_ff),
      .done     (dv_done),
      .quotient (dv_q)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_pos[mem_waddr]  <= wd_pos;
         mem_vel[mem_waddr]  <= wd_vel;
         mem_life[mem_waddr] <= wd_life;
         mem_maxl[mem_waddr] <= wd_maxl;
         mem_misc[mem_waddr] <= wd_misc;
      end
      rd_pos  <= mem_pos[mem_raddr];
      rd_vel  <= mem_vel[mem_raddr];
      rd_life <= mem_life[mem_raddr];
      rd_maxl <= mem_maxl[mem_raddr];
      rd_misc <= mem_misc[mem_raddr];
   end

   // colour interpolation operands for the current channel
   always_comb begin
      ch_a    = w_misc_ff[16 + 8*ax_ff +: 8];
      ch_b    = w_misc_ff[48 + 8*ax_ff +: 8];
      life_c  = (w_life_ff > w_maxl_ff) ? w_maxl_ff : w_life_ff;
      elapsed = w_maxl_ff - life_c;
      dv_num  = 24'(ch_a) * 24'(life_c) + 24'(ch_b) * 24'(elapsed);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ppe_pkg::ST_IDLE: begin
            if (req_valid && !req_stall) begin
               case (ppe_pkg::mode_type'(req_mode))
                  ppe_pkg::MODE_SPAWN: state_in = ppe_pkg::ST_SCAN;
                  ppe_pkg::MODE_TICK:  state_in = ppe_pkg::ST_TICK_RD;
                  ppe_pkg::MODE_READ:  state_in = ppe_pkg::ST_READ_RD;
                  default:             state_in = ppe_pkg::ST_DONE;
               endcase
            end
         end
         ppe_pkg::ST_SCAN: begin
            if (!live_ff[cur_slot] || cnt_ff == CB'(ppe_pkg::PoolSize - 1)) begin
               state_in = ppe_pkg::ST_SPAWN_WR;
            end
         end
         ppe_pkg::ST_SPAWN_WR: state_in = ppe_pkg::ST_DONE;
         ppe_pkg::ST_TICK_RD: begin
            if (cnt_ff == CB'(ppe_pkg::PoolSize)) begin
               state_in = ppe_pkg::ST_DONE;
            end else if (live_ff[cur_slot]) begin
               state_in = ppe_pkg::ST_TICK_LIFE;
            end
         end
         ppe_pkg::ST_TICK_LIFE: begin
            if (l16 <= {4'd0, dt_ff}) begin
               state_in = ppe_pkg::ST_TICK_RD;
            end else begin
               state_in = ppe_pkg::ST_TICK_VY;
            end
         end
         ppe_pkg::ST_TICK_VY: state_in = ppe_pkg::ST_TICK_AX;
         ppe_pkg::ST_TICK_AX: begin
            if (ax_ff == 2'd2) begin
               state_in = ppe_pkg::ST_TICK_WR;
            end
         end
         ppe_pkg::ST_TICK_WR: state_in = ppe_pkg::ST_TICK_RD;
         ppe_pkg::ST_READ_RD: begin
            if (idx_ff >= 8'(ppe_pkg::PoolSize - 1) && ppe_pkg::PoolSize < 256
                && idx_ff != 8'(ppe_pkg::PoolSize - 1)) begin
               state_in = ppe_pkg::ST_DONE;
            end else begin
               state_in = ppe_pkg::ST_READ_DIV;
            end
         end
         ppe_pkg::ST_READ_DIV: begin
            // the slot copy lands in the working registers on the first cycle
            if ((cnt_ff != '0 && w_maxl_ff == 16'd0) || (dv_done && ax_ff == 2'd3)) begin
               state_in = ppe_pkg::ST_DONE;
            end
         end
         ppe_pkg::ST_DONE: begin
            if (!ovalid_ff || !rsp_stall) begin
               state_in = ppe_pkg::ST_IDLE;
            end
         end
         default: state_in = ppe_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      idx_in   = idx_ff;   pos_q_in = pos_q_ff;
      vel_q_in  = vel_q_ff;  size_q_in = size_q_ff; life_q_in = life_q_ff;
      grav_q_in = grav_q_ff; col_q_in = col_q_ff; add_q_in = add_q_ff;
      dt_in     = dt_ff;
      cnt_in    = cnt_ff;    ax_in    = ax_ff;
      live_in   = live_ff;   head_in  = head_ff;
      w_pos_in  = w_pos_ff;  w_vel_in = w_vel_ff; w_life_in = w_life_ff;
      w_maxl_in = w_maxl_ff; w_misc_in = w_misc_ff;
      colour_in = colour_ff;
      ovalid_in = ovalid_ff;
      o_slot_in = o_slot_ff; o_ovw_in = o_ovw_ff; o_act_in = o_act_ff;
      o_add_in  = o_add_ff;  o_pos_in = o_pos_ff; o_size_in = o_size_ff;
      o_col_in  = o_col_ff;
      mem_we    = 1'b0;
      mem_waddr = cur_slot;
      mem_raddr = cur_slot;
      wd_pos    = w_pos_ff;  wd_vel = w_vel_ff; wd_life = w_life_ff;
      wd_maxl   = w_maxl_ff; wd_misc = w_misc_ff;
      sc_a      = $signed(w_misc_ff[31+16 +: 16]);
      sc_base   = $signed(w_vel_ff[31:16]);
      sc_sub    = 1'b0;
      dv_start  = 1'b0;
      // the result register doubles as working storage, so hold off new words
      // until the previous result has left
      req_stall = (state_ff != ppe_pkg::ST_IDLE) || (ovalid_ff && rsp_stall);

      if (ovalid_ff && !rsp_stall) begin
         ovalid_in = 1'b0;
      end

      case (state_ff)
         ppe_pkg::ST_IDLE: begin
            if (req_valid && !req_stall) begin
               idx_in = req_slot_index;
               pos_q_in = req_position; vel_q_in = req_velocity;
               size_q_in = req_particle_size; life_q_in = req_lifetime;
               grav_q_in = req_gravity_accel; col_q_in = req_colours;
               add_q_in = req_additive_blend; dt_in = req_time_step;
               cnt_in = '0;
               ax_in  = '0;
               o_slot_in = '0; o_ovw_in = 1'b0; o_act_in = 1'b0;
               o_add_in = 1'b0; o_pos_in = '0; o_size_in = '0;
               o_col_in = '0;
            end
         end
         ppe_pkg::ST_SCAN: begin
            if (!live_ff[cur_slot]) begin
               o_slot_in = 8'(cur_slot);
            end else if (cnt_ff == CB'(ppe_pkg::PoolSize - 1)) begin
               o_slot_in = 8'(head_ff);
               o_ovw_in  = 1'b1;
               head_in   = head_ff + SB'(1);
            end else begin
               cnt_in = cnt_ff + CB'(1);
            end
         end
         ppe_pkg::ST_SPAWN_WR: begin
            mem_we    = 1'b1;
            mem_waddr = o_slot_ff[SB-1:0];
            wd_pos    = pos_q_ff;
            wd_vel    = vel_q_ff;
            wd_life   = life_q_ff;
            wd_maxl   = life_q_ff;
            wd_misc   = {add_q_ff, grav_q_ff, col_q_ff, size_q_ff};
            live_in[o_slot_ff[SB-1:0]] = 1'b1;
         end
         ppe_pkg::ST_TICK_RD: begin
            if (cnt_ff != CB'(ppe_pkg::PoolSize) && !live_ff[cur_slot]) begin
               cnt_in = cnt_ff + CB'(1);
            end
         end
         ppe_pkg::ST_TICK_LIFE: begin
            w_pos_in = rd_pos; w_vel_in = rd_vel; w_life_in = rd_life;
            w_maxl_in = rd_maxl; w_misc_in = rd_misc;
            if ({rd_life, 4'd0} <= {4'd0, dt_ff}) begin
               live_in[cur_slot] = 1'b0;
               cnt_in = cnt_ff + CB'(1);
            end else begin
               w_life_in = 16'(({rd_life, 4'd0} - {4'd0, dt_ff}) >> 4);
            end
            ax_in = '0;
         end
         ppe_pkg::ST_TICK_VY: begin
            sc_a    = $signed(w_misc_ff[95:80]);
            sc_base = $signed(w_vel_ff[31:16]);
            sc_sub  = 1'b1;
            w_vel_in[31:16] = sc_res;
         end
         ppe_pkg::ST_TICK_AX: begin
            sc_a    = $signed(w_vel_ff[16*ax_ff +: 16]);
            sc_base = $signed(w_pos_ff[16*ax_ff +: 16]);
            w_pos_in[16*ax_ff +: 16] = sc_res;
            ax_in = ax_ff + 2'd1;
         end
         ppe_pkg::ST_TICK_WR: begin
            mem_we = 1'b1;
            cnt_in = cnt_ff + CB'(1);
         end
         ppe_pkg::ST_READ_RD: begin
            mem_raddr = idx_ff[SB-1:0];
            ax_in = '0;
         end
         ppe_pkg::ST_READ_DIV: begin
            if (ax_ff == 2'd0 && !dv_done && colour_ff == 32'd0 && cnt_ff == '0) begin
               w_pos_in = rd_pos; w_life_in = rd_life; w_maxl_in = rd_maxl;
               w_misc_in = rd_misc;
               cnt_in = CB'(1);
               o_act_in  = live_ff[idx_ff[SB-1:0]];
               o_add_in  = rd_misc[96];
               o_pos_in  = rd_pos;
               o_size_in = rd_misc[15:0];
            end else if (w_maxl_ff == 16'd0) begin
               o_col_in = w_misc_ff[47:16];
            end else if (cnt_ff == CB'(1)) begin
               dv_start = 1'b1;
               cnt_in = CB'(2);
            end else if (dv_done) begin
               colour_in[8*ax_ff +: 8] = dv_q;
               if (ax_ff == 2'd3) begin
                  o_col_in = {dv_q, colour_ff[23:0]};
               end else begin
                  ax_in = ax_ff + 2'd1;
                  cnt_in = CB'(1);
               end
            end
         end
         ppe_pkg::ST_DONE: begin
            if (!ovalid_ff || !rsp_stall) begin
               ovalid_in = 1'b1;
               colour_in = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in; pos_q_ff <= pos_q_in;
      vel_q_ff <= vel_q_in; size_q_ff <= size_q_in; life_q_ff <= life_q_in;
      grav_q_ff <= grav_q_in; col_q_ff <= col_q_in; add_q_ff <= add_q_in;
      dt_ff <= dt_in; ax_ff <= ax_in;
      w_pos_ff <= w_pos_in; w_vel_ff <= w_vel_in; w_life_ff <= w_life_in;
      w_maxl_ff <= w_maxl_in; w_misc_ff <= w_misc_in;
      o_slot_ff <= o_slot_in; o_ovw_ff <= o_ovw_in; o_act_ff <= o_act_in;
      o_add_ff <= o_add_in; o_pos_ff <= o_pos_in; o_size_ff <= o_size_in;
      o_col_ff <= o_col_in;
      if (reset) begin
         state_ff  <= ppe_pkg::ST_IDLE;
         live_ff   <= '0;
         head_ff   <= '0;
         ovalid_ff <= 1'b0;
         cnt_ff    <= '0;
         colour_ff <= '0;
      end else begin
         state_ff  <= state_in;
         live_ff   <= live_in;
         head_ff   <= head_in;
         ovalid_ff <= ovalid_in;
         cnt_ff    <= (state_in == ppe_pkg::ST_IDLE) ? '0 : cnt_in;
         colour_ff <= colour_in;
      end
   end

   assign rsp_valid        = ovalid_ff;
   assign rsp_taken_slot   = o_slot_ff;
   assign rsp_overwrote    = o_ovw_ff;
   assign rsp_is_active    = o_act_ff;
   assign rsp_is_additive  = o_add_ff;
   assign rsp_cur_position = o_pos_ff;
   assign rsp_cur_size     = o_size_ff;
   assign rsp_cur_colour   = o_col_ff;
endmodule

[design/ppe_scale.sv]
// Shared unit: floor(a * dt / 65536), added to base (subtracted when sub is set), saturated to 16 bits.
module ppe_scale (
   input  logic signed [15:0] a,
   input  logic        [15:0] dt,
   input  logic signed [15:0] base,
   input  logic               sub,
   output logic signed [15:0] result
);
   logic signed [32:0] prod;
   logic signed [16:0] q;
   logic signed [18:0] sum;

   always_comb begin
      prod = a * $signed({1'b0, dt});
      q    = prod[32:16];   // arithmetic shift is floor
      if (sub) begin
         sum = 19'(base) - 19'(q);
      end else begin
         sum = 19'(base) + 19'(q);
      end
      result = ppe_pkg::sat16(sum);
   end
endmodule

[design/ppe_div.sv]
// Restoring divider: 24-bit dividend by 16-bit divisor, one bit per cycle.
module ppe_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [23:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [7:0]  quotient
);
   logic [23:0] quo_ff, quo_in;
   logic [16:0] rem_ff, rem_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [16:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[15:0], quo_ff[23]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = 5'd24;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = trial - {1'b0, divisor};
            quo_in = {quo_ff[22:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[22:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign done     = busy_ff && (cnt_ff == 5'd1);
   assign quotient = quo_in[7:0];
endmodule

[test/particle_pool_checker.sv]
`timescale 1ns / 100ps

// Watches both channels, keeps a private copy of the pool, predicts the
// response word for every accepted request word and compares in order.
module particle_pool_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_slot_index,
   input  logic [47:0] req_position,
   input  logic [47:0] req_velocity,
   input  logic [15:0] req_particle_size,
   input  logic [15:0] req_lifetime,
   input  logic [15:0] req_gravity_accel,
   input  logic [63:0] req_colours,
   input  logic        req_additive_blend,
   input  logic [15:0] req_time_step,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_taken_slot,
   input  logic        rsp_overwrote,
   input  logic        rsp_is_active,
   input  logic        rsp_is_additive,
   input  logic [47:0] rsp_cur_position,
   input  logic [15:0] rsp_cur_size,
   input  logic [31:0] rsp_cur_colour,
   output int          fail_count,
   output int          pending
);

   typedef struct {
      logic [7:0]  taken_slot;
      logic        overwrote;
      logic        is_active;
      logic        is_additive;
      logic [47:0] cur_position;
      logic [15:0] cur_size;
      logic [31:0] cur_colour;
   } pool_word_type;

   pool_word_type expected_words[$];

   bit          live[ppe_pkg::PoolSize];
   logic [7:0]  head;
   logic [47:0] pos[ppe_pkg::PoolSize];
   logic [47:0] vel[ppe_pkg::PoolSize];
   logic [15:0] life[ppe_pkg::PoolSize];
   logic [15:0] max_life[ppe_pkg::PoolSize];
   logic [15:0] size[ppe_pkg::PoolSize];
   logic [15:0] grav[ppe_pkg::PoolSize];
   logic [63:0] col[ppe_pkg::PoolSize];
   bit          add[ppe_pkg::PoolSize];

   initial begin
      fail_count = 0;
      head = '0;
      foreach (live[i]) begin
         live[i] = 0;
      end
   end

   assign pending = expected_words.size();

   function automatic logic [15:0] clamp16(longint v);
      if (v > 32767) begin
         return 16'h7fff;
      end
      if (v < -32768) begin
         return 16'h8000;
      end
      return v[15:0];
   endfunction

   // floor(a * dt / 2^16); arithmetic shift floors negatives
   function automatic longint step_scale(logic [15:0] a, logic [15:0] dt);
      longint p;
      p = longint'($signed(a)) * longint'({1'b0, dt});
      return p >>> 16;
   endfunction

   function automatic logic [31:0] fade_colour(logic [63:0] c, logic [15:0] l,
                                               logic [15:0] m);
      logic [31:0] out;
      longint      lv, e, a, b;
      if (m == 0) begin
         return c[31:0];
      end
      lv = (l > m) ? m : l;
      e = m - lv;
      for (int k = 0; k < 4; k++) begin
         a = c[8*k +: 8];
         b = c[32 + 8*k +: 8];
         out[8*k +: 8] = 8'((a * lv + b * e) / m);
      end
      return out;
   endfunction

   task automatic age_pool(logic [15:0] dt);
      logic [19:0] l16;
      logic [15:0] vy;
      for (int i = 0; i < ppe_pkg::PoolSize; i++) begin
         if (live[i]) begin
            l16 = {life[i], 4'b0};
            if (l16 <= dt) begin
               live[i] = 0;
            end else begin
               life[i] = 16'((l16 - dt) >> 4);
               vy = clamp16(longint'($signed(vel[i][31:16])) - step_scale(grav[i], dt));
               vel[i][31:16] = vy;
               for (int k = 0; k < 3; k++) begin
                  pos[i][16*k +: 16] = clamp16(longint'($signed(pos[i][16*k +: 16]))
                                               + step_scale(vel[i][16*k +: 16], dt));
               end
            end
         end
      end
   endtask

   task automatic predict_word();
      pool_word_type w;
      int            s;
      bit            found;
      w = '{default: '0};
      case (ppe_pkg::mode_type'(req_mode))
         ppe_pkg::MODE_SPAWN: begin
            found = 0;
            s = 0;
            for (int i = 0; i < ppe_pkg::PoolSize; i++) begin
               if (!found && !live[i]) begin
                  s = i;
                  found = 1;
               end
            end
            if (!found) begin
               s = head;
               head = head + 1;
            end
            live[s] = 1;
            pos[s] = req_position;
            vel[s] = req_velocity;
            life[s] = req_lifetime;
            max_life[s] = req_lifetime;
            size[s] = req_particle_size;
            grav[s] = req_gravity_accel;
            col[s] = req_colours;
            add[s] = req_additive_blend;
            w.taken_slot = s[7:0];
            w.overwrote = !found;
         end
         ppe_pkg::MODE_TICK: begin
            age_pool(req_time_step);
         end
         ppe_pkg::MODE_READ: begin
            s = req_slot_index;
            w.is_active = live[s];
            w.is_additive = add[s];
            w.cur_position = pos[s];
            w.cur_size = size[s];
            w.cur_colour = fade_colour(col[s], life[s], max_life[s]);
         end
         default: begin
         end
      endcase
      expected_words.push_back(w);
   endtask

   task automatic report(string field, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", field, got, want, $realtime);
      fail_count++;
   endtask

   task automatic compare_word();
      pool_word_type w;
      if (expected_words.size() == 0) begin
         report("unexpected word", 0, 0);
         return;
      end
      w = expected_words.pop_front();
      if (rsp_taken_slot !== w.taken_slot) report("taken_slot", rsp_taken_slot, w.taken_slot);
      if (rsp_overwrote !== w.overwrote) report("overwrote", rsp_overwrote, w.overwrote);
      if (rsp_is_active !== w.is_active) report("is_active", rsp_is_active, w.is_active);
      if (rsp_is_additive !== w.is_additive)
         report("is_additive", rsp_is_additive, w.is_additive);
      if (rsp_cur_position !== w.cur_position)
         report("cur_position", rsp_cur_position, w.cur_position);
      if (rsp_cur_size !== w.cur_size) report("cur_size", rsp_cur_size, w.cur_size);
      if (rsp_cur_colour !== w.cur_colour) report("cur_colour", rsp_cur_colour, w.cur_colour);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            compare_word();
         end
         if (req_valid && !req_stall) begin
            predict_word();
         end
      end
   end

endmodule

[test/particle_pool_engine_test.sv]
`timescale 1ns / 100ps

// Top of the pool test: drives request words, random back-pressure on the
// response side, a watchdog, and the verdict. All checking is done in
// particle_pool_checker.
module particle_pool_engine_test;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_mode;
   logic [7:0]  req_slot_index;
   logic [47:0] req_position;
   logic [47:0] req_velocity;
   logic [15:0] req_particle_size;
   logic [15:0] req_lifetime;
   logic [15:0] req_gravity_accel;
   logic [63:0] req_colours;
   logic        req_additive_blend;
   logic [15:0] req_time_step;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_taken_slot;
   logic        rsp_overwrote;
   logic        rsp_is_active;
   logic        rsp_is_additive;
   logic [47:0] rsp_cur_position;
   logic [15:0] rsp_cur_size;
   logic [31:0] rsp_cur_colour;

   int fail_count;
   int pending;
   bit quiet;        // no idling on either side near the end
   int idle_cycles;  // cycles with no word moved on either channel

   // the limit covers a full tick of a live pool, plus stall bursts on the result side
   localparam int WatchdogLimit = 20000;

   particle_pool_engine u_dut (.*);

   particle_pool_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // result side back-pressure: random stall bursts, none while quiet
   initial begin
      rsp_stall <= 0;
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
         rsp_stall <= 0;
      end
   end

   // watchdog on progress of either channel
   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WatchdogLimit) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // present one word and hold it until accepted
   task automatic send_word(ppe_pkg::mode_type m, logic [7:0] idx, logic [47:0] p,
                            logic [47:0] v, logic [15:0] sz, logic [15:0] lt,
                            logic [15:0] g, logic [63:0] c, logic ab,
                            logic [15:0] dt);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid          <= 1;
      req_mode           <= m;
      req_slot_index     <= idx;
      req_position       <= p;
      req_velocity       <= v;
      req_particle_size  <= sz;
      req_lifetime       <= lt;
      req_gravity_accel  <= g;
      req_colours        <= c;
      req_additive_blend <= ab;
      req_time_step      <= dt;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic [15:0] rand_axis();
      case ($urandom_range(0, 5))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'($urandom_range(0, 511)) - 16'd256;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [47:0] rand_vec();
      return {rand_axis(), rand_axis(), rand_axis()};
   endfunction

   // short lives mostly, so ticks free slots and spawns find holes
   function automatic logic [15:0] rand_life();
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 15));
         default: return 16'($urandom_range(0, 12000));
      endcase
   endfunction

   task automatic spawn_random();
      send_word(ppe_pkg::MODE_SPAWN, 8'($urandom), rand_vec(), rand_vec(), 16'($urandom),
                rand_life(), rand_axis(), {$urandom, $urandom}, 1'($urandom),
                16'($urandom));
   endtask

   task automatic other_random(ppe_pkg::mode_type m);
      logic [15:0] dt;
      dt = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000));
      send_word(m, 8'($urandom), 48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                16'($urandom), 16'($urandom), 16'($urandom), {$urandom, $urandom},
                1'($urandom), dt);
   endtask

   task automatic read_slot(logic [7:0] s);
      send_word(ppe_pkg::MODE_READ, s, '0, '0, '0, '0, '0, '0, 0, '0);
   endtask

   task automatic tick_pool(logic [15:0] dt);
      send_word(ppe_pkg::MODE_TICK, '0, '0, '0, '0, '0, '0, '0, 0, dt);
   endtask

   initial begin
      int pick;
      int waited;
      quiet = 0;
      reset <= 1;
      req_valid <= 0;
      req_mode <= ppe_pkg::MODE_NOP;
      req_slot_index <= '0;
      req_position <= '0;
      req_velocity <= '0;
      req_particle_size <= '0;
      req_lifetime <= '0;
      req_gravity_accel <= '0;
      req_colours <= '0;
      req_additive_blend <= 0;
      req_time_step <= '0;
      repeat (11) @(posedge clock);
      reset <= 0;

      // directed: empty pool hands out slots 0, 1, 2 in order
      send_word(ppe_pkg::MODE_SPAWN, 8'hff, {3{16'h7fff}}, {3{16'h7fff}}, 16'hffff,
                16'hffff, 16'h8000, 64'hffffffff_00000000, 1, 16'hffff);
      send_word(ppe_pkg::MODE_SPAWN, 8'h00, {3{16'h8000}}, {3{16'h8000}}, 16'h0000,
                16'h0000, 16'h7fff, 64'h00000000_ffffffff, 0, 16'h0000);   // zero life
      send_word(ppe_pkg::MODE_SPAWN, 8'h55, 48'h0100_ff00_0080, 48'h0200_fe00_0100,
                16'h1000, 16'h1000, 16'h0980, 64'h80402010_10204080, 1, 16'h8000);
      read_slot(0);
      read_slot(1);   // zero max life: start colour
      read_slot(2);
      tick_pool(16'h0000);   // zero step frees the zero-life slot
      read_slot(1);
      tick_pool(16'hffff);
      read_slot(0);
      read_slot(2);
      send_word(ppe_pkg::MODE_NOP, 8'hff, '1, '1, '1, '1, '1, '1, 1, '1);
      tick_pool(16'h4000);
      read_slot(0);
      read_slot(2);
      spawn_random();
      read_slot(1);

      // fill the pool so every slot has been written before random reads
      repeat (256) spawn_random();

      for (int n = 0; n < 920; n++) begin
         if (n >= 780) begin
            quiet = 1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            spawn_random();
         end else if (pick < 58) begin
            other_random(ppe_pkg::MODE_TICK);
         end else if (pick < 95) begin
            other_random(ppe_pkg::MODE_READ);
         end else begin
            other_random(ppe_pkg::MODE_NOP);
         end
      end
      req_valid <= 0;

      waited = 0;
      while (pending != 0 && waited < WatchdogLimit) begin
         @(posedge clock);
         waited++;
      end
      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
